FILE: rtl/delay_ecn_congestion_estimator_top_defines.svh
// Assertion macros shared by the checker of the congestion estimator.
// No dependencies; include by bare file name.
`ifndef DELAY_ECN_CONGESTION_ESTIMATOR_TOP_DEFINES_SVH
`define DELAY_ECN_CONGESTION_ESTIMATOR_TOP_DEFINES_SVH

// same-cycle implication, silent during reset
`define DECE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, silent during reset
`define DECE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/dece_pkg.sv
// Constants and helpers for the delay/ECN congestion estimator.
// No dependencies; imported by the top level and its checker.
package dece_pkg;
   localparam int unsigned QONE_W = 11;
   localparam logic [QONE_W-1:0] Q_ONE = 11'd1024;
   localparam logic [3:0] MAX_SHIFT = 4'd10;

   localparam logic [1:0] REG_GAIN_SHIFT      = 2'd0;
   localparam logic [1:0] REG_ALPHA_INITIAL   = 2'd1;
   localparam logic [1:0] REG_QUEUE_THRESHOLD = 2'd2;
   localparam logic [1:0] REG_SEGMENT_BYTES   = 2'd3;

   localparam logic [1:0] KIND_OTHER    = 2'd0;
   localparam logic [1:0] KIND_ELEPHANT = 2'd1;
   localparam logic [1:0] KIND_MOUSE    = 2'd2;

   localparam logic [3:0]  GAIN_RESET  = 4'd4;
   localparam logic [10:0] ALPHA_RESET = 11'd1024;
   localparam logic [15:0] THR_RESET   = 16'd5;
   localparam logic [13:0] SEG_RESET   = 14'd536;

   function automatic logic [10:0] clamp_alpha(input logic [10:0] a);
      clamp_alpha = (a > Q_ONE) ? Q_ONE : a;
   endfunction
endpackage

FILE: rtl/delay_ecn_congestion_estimator_top.sv
// Delay/ECN congestion estimator (DCTCP-style alpha) with one shared multiplier
// and one shared radix-2 divider under a sequencer. Depends on dece_pkg.
//
//  channel | direction | handshake              | word
//  req     | in        | req_valid / req_ready  | one ACK event
//  rsp     | out       | rsp_valid / rsp_ready  | alpha, windows, flags
//  csr     | in/out    | APB psel/penable/pready| 4 x 32-bit registers
//
// An ACK is taken only while the sequencer is idle. An rtt sample adds the
// cwnd/segment and queue divisions; a round end adds the fraction division,
// and the cut steps when the window is cut. All three divisions run on the
// single bit-per-cycle divider.
// Reset is synchronous, active high; clears control, counters and registers.
// A waiting result sits in the output register while the next ACK is taken;
// the sequencer holds in its last step only if that register is still full.
module delay_ecn_congestion_estimator_top
   import dece_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_segments_acked,
   input  logic [23:0] req_rtt_sample_us,
   input  logic [23:0] req_min_rtt_us,
   input  logic [31:0] req_cwnd_bytes,
   input  logic        req_ece_received,
   input  logic [1:0]  req_flow_kind,
   input  logic [31:0] req_last_acked_seq,
   input  logic [31:0] req_next_tx_seq,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [10:0] rsp_alpha_now,
   output logic [31:0] rsp_cwnd_new,
   output logic [31:0] rsp_ssthresh_new,
   output logic        rsp_window_cut,
   output logic        rsp_round_closed,
   output logic [31:0] rsp_cwr_threshold,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   // sequencer steps
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BYTES = 4'd1;   // segs * segment size
   localparam logic [3:0] S_ACC   = 4'd2;   // count bytes, latch round end
   localparam logic [3:0] S_DSEG  = 4'd3;   // cwnd / segment size
   localparam logic [3:0] S_MQ    = 4'd4;   // segments * (rtt - base)
   localparam logic [3:0] S_LDQ   = 4'd5;
   localparam logic [3:0] S_DQ    = 4'd6;   // ... / rtt
   localparam logic [3:0] S_THR   = 4'd7;
   localparam logic [3:0] S_ROUND = 4'd8;
   localparam logic [3:0] S_DFRAC = 4'd9;   // count * 1024 / total
   localparam logic [3:0] S_EWMA  = 4'd10;
   localparam logic [3:0] S_MCUT  = 4'd11;
   localparam logic [3:0] S_CUT   = 4'd12;
   localparam logic [3:0] S_MCWR  = 4'd13;
   localparam logic [3:0] S_OUT   = 4'd14;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      sat_add = s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // configuration
   logic [3:0]  gain_ff, gain_in;
   logic [10:0] ainit_ff, ainit_in;
   logic [15:0] thr_ff, thr_in;
   logic [13:0] seg_ff, seg_in;
   // estimator state
   logic [31:0] ecn_cnt_ff, ecn_cnt_in, dly_cnt_ff, dly_cnt_in, tot_cnt_ff, tot_cnt_in;
   logic [31:0] rend_seq_ff, rend_seq_in;
   logic        rend_vld_ff, rend_vld_in, dsig_ff, dsig_in;
   logic [10:0] a_ecn_ff, a_ecn_in, a_dly_ff, a_dly_in, a_cur_ff, a_cur_in;
   // latched ACK
   logic [15:0] segs_ff, segs_in;
   logic [23:0] rtt_ff, rtt_in, minr_ff, minr_in;
   logic [31:0] cwnd_ff, cwnd_in, acked_ff, acked_in, nxt_ff, nxt_in;
   logic        ece_ff, ece_in;
   logic [1:0]  kind_ff, kind_in;
   // datapath
   logic [3:0]  st_ff, st_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [55:0] prod_ff, prod_in;
   logic [31:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [55:0] quo_ff, quo_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        closed_ff, closed_in, cut_ff, cut_in;
   logic [31:0] cwn_ff, cwn_in, ssth_ff, ssth_in;
   // output register
   logic        ov_ff, ov_in, ocut_ff, ocut_in, oclosed_ff, oclosed_in;
   logic [10:0] oalpha_ff, oalpha_in;
   logic [31:0] ocwnd_ff, ocwnd_in, ossth_ff, ossth_in, ocwr_ff, ocwr_in;

   logic [13:0] seg_eff;
   logic [23:0] base, rdiff;
   logic [31:0] mul_a;
   logic [23:0] mul_b;
   logic [32:0] rem_sh;
   logic        rem_ge;
   logic        csr_wr;
   logic [31:0] rdist;
   logic [10:0] frac, a_old, a_new;
   logic [3:0]  shamt;
   logic [22:0] num;
   logic [31:0] cut_val;
   logic [14:0] floor2;
   logic [31:0] cnt_sel;

   assign seg_eff = (seg_ff == 14'd0) ? 14'd1 : seg_ff;
   assign base    = (minr_ff > rtt_ff) ? rtt_ff : minr_ff;
   assign rdiff   = rtt_ff - base;
   assign csr_wr  = csr_psel & csr_penable & csr_pwrite;
   assign rdist   = acked_ff - rend_seq_ff;
   assign rem_sh  = {rem_ff, quo_ff[55]};
   assign rem_ge  = rem_sh >= {1'b0, dvs_ff};
   assign frac    = (quo_ff > {45'd0, Q_ONE}) ? Q_ONE : quo_ff[10:0];
   assign a_old   = (kind_ff == KIND_ELEPHANT) ? a_dly_ff : a_ecn_ff;
   assign shamt   = (gain_ff > MAX_SHIFT) ? MAX_SHIFT : gain_ff;
   assign num     = (({12'd0, a_old} << shamt) - {12'd0, a_old} + {12'd0, frac}) >> shamt;
   assign a_new   = num[10:0];
   assign cut_val = prod_ff[42:11];
   assign floor2  = {seg_eff, 1'b0};
   assign cnt_sel = (kind_ff == KIND_ELEPHANT) ? dly_cnt_ff : ecn_cnt_ff;

   // shared multiplier operands
   always_comb begin
      unique case (st_ff)
         S_BYTES: begin
            mul_a = {16'd0, segs_ff};
            mul_b = {10'd0, seg_eff};
         end
         S_MQ: begin
            mul_a = quo_ff[31:0];
            mul_b = rdiff;
         end
         S_MCUT: begin
            mul_a = cwnd_ff;
            mul_b = {12'd0, 12'd2048 - {1'b0, a_dly_ff}};
         end
         S_MCWR: begin
            mul_a = cwn_ff;
            mul_b = {12'd0, 12'd2048 - {1'b0, a_cur_ff}};
         end
         default: begin
            mul_a = 32'd0;
            mul_b = 24'd0;
         end
      endcase
   end

   always_comb begin
      gain_in = gain_ff;  ainit_in = ainit_ff;  thr_in = thr_ff;  seg_in = seg_ff;
      ecn_cnt_in = ecn_cnt_ff;  dly_cnt_in = dly_cnt_ff;  tot_cnt_in = tot_cnt_ff;
      rend_seq_in = rend_seq_ff;  rend_vld_in = rend_vld_ff;  dsig_in = dsig_ff;
      a_ecn_in = a_ecn_ff;  a_dly_in = a_dly_ff;  a_cur_in = a_cur_ff;
      segs_in = segs_ff;  rtt_in = rtt_ff;  minr_in = minr_ff;  cwnd_in = cwnd_ff;
      acked_in = acked_ff;  nxt_in = nxt_ff;  ece_in = ece_ff;  kind_in = kind_ff;
      st_in = st_ff;  bytes_in = bytes_ff;  prod_in = {24'd0, mul_a} * {32'd0, mul_b};
      rem_in = rem_ff;  dvs_in = dvs_ff;  quo_in = quo_ff;  cnt_in = cnt_ff;
      closed_in = closed_ff;  cut_in = cut_ff;  cwn_in = cwn_ff;  ssth_in = ssth_ff;
      ov_in = ov_ff & ~rsp_ready;
      ocut_in = ocut_ff;  oclosed_in = oclosed_ff;  oalpha_in = oalpha_ff;
      ocwnd_in = ocwnd_ff;  ossth_in = ossth_ff;  ocwr_in = ocwr_ff;

      // one divider step per cycle in the division states
      if (st_ff == S_DSEG || st_ff == S_DQ || st_ff == S_DFRAC) begin
         if (rem_ge) begin
            rem_in = rem_sh[31:0] - dvs_ff;
            quo_in = {quo_ff[54:0], 1'b1};
         end else begin
            rem_in = rem_sh[31:0];
            quo_in = {quo_ff[54:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end

      unique case (st_ff)
         S_IDLE: begin
            if (req_valid) begin
               segs_in = req_segments_acked;  rtt_in = req_rtt_sample_us;
               minr_in = req_min_rtt_us;  cwnd_in = req_cwnd_bytes;
               ece_in = req_ece_received;  kind_in = req_flow_kind;
               acked_in = req_last_acked_seq;  nxt_in = req_next_tx_seq;
               st_in = S_BYTES;
            end
         end
         S_BYTES: st_in = S_ACC;
         S_ACC: begin
            bytes_in = prod_ff[31:0];
            tot_cnt_in = sat_add(tot_cnt_ff, prod_ff[31:0]);
            if (ece_ff) ecn_cnt_in = sat_add(ecn_cnt_ff, prod_ff[31:0]);
            if (!rend_vld_ff) begin
               rend_seq_in = nxt_ff;
               rend_vld_in = 1'b1;
            end
            if (rtt_ff != 24'd0) begin
               rem_in = 32'd0;
               quo_in = {cwnd_ff, 24'd0};
               dvs_in = {18'd0, seg_eff};
               cnt_in = 6'd32;
               st_in = S_DSEG;
            end else begin
               st_in = S_ROUND;
            end
         end
         S_DSEG: if (cnt_ff == 6'd1) st_in = S_MQ;
         S_MQ:   st_in = S_LDQ;
         S_LDQ: begin
            rem_in = 32'd0;
            quo_in = prod_ff;
            dvs_in = {8'd0, rtt_ff};
            cnt_in = 6'd56;
            st_in = S_DQ;
         end
         S_DQ: if (cnt_ff == 6'd1) st_in = S_THR;
         S_THR: begin
            if (quo_ff >= {40'd0, thr_ff}) begin
               dsig_in = 1'b1;
               dly_cnt_in = sat_add(dly_cnt_ff, bytes_ff);
            end
            st_in = S_ROUND;
         end
         S_ROUND: begin
            cut_in = 1'b0;
            closed_in = (kind_ff == KIND_ELEPHANT || kind_ff == KIND_MOUSE) && !rdist[31];
            cwn_in = cwnd_ff;
            ssth_in = cwnd_ff;
            if (!((kind_ff == KIND_ELEPHANT || kind_ff == KIND_MOUSE) && !rdist[31])) begin
               st_in = S_MCWR;
            end else if (tot_cnt_ff == 32'd0) begin
               quo_in = 56'd0;
               st_in = S_EWMA;
            end else begin
               rem_in = 32'd0;
               quo_in = {cnt_sel, 10'd0, 14'd0};
               dvs_in = tot_cnt_ff;
               cnt_in = 6'd42;
               st_in = S_DFRAC;
            end
         end
         S_DFRAC: if (cnt_ff == 6'd1) st_in = S_EWMA;
         S_EWMA: begin
            if (kind_ff == KIND_ELEPHANT) a_dly_in = a_new;
            else a_ecn_in = a_new;
            a_cur_in = a_new;
            rend_seq_in = nxt_ff;
            ecn_cnt_in = 32'd0;  dly_cnt_in = 32'd0;  tot_cnt_in = 32'd0;
            dsig_in = 1'b0;
            st_in = (kind_ff == KIND_ELEPHANT && dsig_ff) ? S_MCUT : S_MCWR;
         end
         S_MCUT: st_in = S_CUT;
         S_CUT: begin
            cwn_in = (cut_val > {17'd0, floor2}) ? cut_val : {17'd0, floor2};
            ssth_in = (cut_val > {17'd0, floor2}) ? cut_val : {17'd0, floor2};
            cut_in = 1'b1;
            st_in = S_MCWR;
         end
         S_MCWR: st_in = S_OUT;
         S_OUT: begin
            // hold the cwr product and wait until the output register is free
            prod_in = prod_ff;
            if (!ov_ff || rsp_ready) begin
               ov_in = 1'b1;
               oalpha_in = a_cur_ff;  ocwnd_in = cwn_ff;  ossth_in = ssth_ff;
               ocut_in = cut_ff;  oclosed_in = closed_ff;  ocwr_in = prod_ff[42:11];
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase

      // the user must make register writes only while idle; the block does not enforce it
      if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_GAIN_SHIFT:      gain_in = csr_pwdata[3:0];
            REG_ALPHA_INITIAL: begin
               ainit_in = csr_pwdata[10:0];
               a_ecn_in = clamp_alpha(csr_pwdata[10:0]);
               a_dly_in = clamp_alpha(csr_pwdata[10:0]);
               a_cur_in = clamp_alpha(csr_pwdata[10:0]);
            end
            REG_QUEUE_THRESHOLD: thr_in = csr_pwdata[15:0];
            REG_SEGMENT_BYTES:   seg_in = csr_pwdata[13:0];
            default:             gain_in = gain_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= GAIN_RESET;  ainit_ff <= ALPHA_RESET;
         thr_ff <= THR_RESET;    seg_ff <= SEG_RESET;
         ecn_cnt_ff <= 32'd0;  dly_cnt_ff <= 32'd0;  tot_cnt_ff <= 32'd0;
         rend_seq_ff <= 32'd0;  rend_vld_ff <= 1'b0;  dsig_ff <= 1'b0;
         a_ecn_ff <= clamp_alpha(ALPHA_RESET);
         a_dly_ff <= clamp_alpha(ALPHA_RESET);
         a_cur_ff <= clamp_alpha(ALPHA_RESET);
         st_ff <= S_IDLE;  ov_ff <= 1'b0;
      end else begin
         gain_ff <= gain_in;  ainit_ff <= ainit_in;  thr_ff <= thr_in;  seg_ff <= seg_in;
         ecn_cnt_ff <= ecn_cnt_in;  dly_cnt_ff <= dly_cnt_in;  tot_cnt_ff <= tot_cnt_in;
         rend_seq_ff <= rend_seq_in;  rend_vld_ff <= rend_vld_in;  dsig_ff <= dsig_in;
         a_ecn_ff <= a_ecn_in;  a_dly_ff <= a_dly_in;  a_cur_ff <= a_cur_in;
         st_ff <= st_in;  ov_ff <= ov_in;
      end
      segs_ff <= segs_in;  rtt_ff <= rtt_in;  minr_ff <= minr_in;  cwnd_ff <= cwnd_in;
      acked_ff <= acked_in;  nxt_ff <= nxt_in;  ece_ff <= ece_in;  kind_ff <= kind_in;
      bytes_ff <= bytes_in;  prod_ff <= prod_in;
      rem_ff <= rem_in;  dvs_ff <= dvs_in;  quo_ff <= quo_in;  cnt_ff <= cnt_in;
      closed_ff <= closed_in;  cut_ff <= cut_in;  cwn_ff <= cwn_in;  ssth_ff <= ssth_in;
      ocut_ff <= ocut_in;  oclosed_ff <= oclosed_in;  oalpha_ff <= oalpha_in;
      ocwnd_ff <= ocwnd_in;  ossth_ff <= ossth_in;  ocwr_ff <= ocwr_in;
   end

   // register readback
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_GAIN_SHIFT:      csr_prdata = {28'd0, gain_ff};
         REG_ALPHA_INITIAL:   csr_prdata = {21'd0, ainit_ff};
         REG_QUEUE_THRESHOLD: csr_prdata = {16'd0, thr_ff};
         REG_SEGMENT_BYTES:   csr_prdata = {18'd0, seg_ff};
         default:             csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready        = 1'b1;
   assign req_ready         = (st_ff == S_IDLE);
   assign rsp_valid         = ov_ff;
   assign rsp_alpha_now     = oalpha_ff;
   assign rsp_cwnd_new      = ocwnd_ff;
   assign rsp_ssthresh_new  = ossth_ff;
   assign rsp_window_cut    = ocut_ff;
   assign rsp_round_closed  = oclosed_ff;
   assign rsp_cwr_threshold = ocwr_ff;
endmodule

FILE: rtl/dece_checker.sv
// Port-level checker for the congestion estimator, bound to the top level.
// Depends on dece_pkg and the assertion macro header.
`include "delay_ecn_congestion_estimator_top_defines.svh"
module dece_checker
   import dece_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [10:0] rsp_alpha_now,
   input logic [31:0] rsp_cwnd_new,
   input logic [31:0] rsp_ssthresh_new,
   input logic        rsp_window_cut,
   input logic        rsp_round_closed
);
   `DECE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped")
   `DECE_ASSERT_NOW(a_alpha_range, clock, reset, rsp_valid, rsp_alpha_now <= Q_ONE, "alpha above one")
   `DECE_ASSERT_NOW(a_cut_round, clock, reset, rsp_valid && rsp_window_cut, rsp_round_closed, "cut without round end")
   `DECE_ASSERT_NOW(a_cut_equal, clock, reset, rsp_valid && rsp_window_cut, rsp_cwnd_new == rsp_ssthresh_new, "cut windows differ")
   `DECE_ASSERT_NEXT(a_busy, clock, reset, req_valid && req_ready, !req_ready, "ready while busy")
endmodule

bind delay_ecn_congestion_estimator_top dece_checker u_dece_checker (.*);

FILE: tb/tb_top.sv
// Self-checking bench for the delay/ECN congestion estimator: ACK words in,
// alpha and window words out, register setup over the csr port.
// Depends on dece_pkg and delay_ecn_congestion_estimator_top.
`timescale 1ns / 1ps

import dece_pkg::*;

localparam logic [1:0] KIND_SPARE = 2'd3;

typedef struct {
   logic [15:0] segs;
   logic [23:0] rtt;
   logic [23:0] min_rtt;
   logic [31:0] cwnd;
   logic        ece;
   logic [1:0]  kind;
   logic [31:0] acked;
   logic [31:0] next_tx;
} ack_word_type;

typedef struct {
   logic [10:0] alpha;
   logic [31:0] cwnd;
   logic [31:0] ssthresh;
   logic        cut;
   logic        closed;
   logic [31:0] cwr;
} window_word_type;

// Tracks the estimator state and holds the windows and alphas still owed.
class alpha_tracker;
   logic [3:0]  gain_shift;
   logic [10:0] alpha_init;
   logic [15:0] queue_thr;
   logic [13:0] seg_bytes;
   logic [31:0] ecn_bytes, delay_bytes, total_bytes, round_end;
   bit          round_armed, delay_flag;
   logic [10:0] alpha_ecn, alpha_delay, alpha_cur;
   window_word_type owed_windows[$];
   int          errors, acks_seen, words_checked, rounds, cuts;

   function new();
      gain_shift = GAIN_RESET;
      alpha_init = ALPHA_RESET;
      queue_thr  = THR_RESET;
      seg_bytes  = SEG_RESET;
      ecn_bytes = 0; delay_bytes = 0; total_bytes = 0; round_end = 0;
      round_armed = 0; delay_flag = 0;
      load_alpha();
   endfunction

   function void load_alpha();
      alpha_ecn   = (alpha_init > 11'd1024) ? 11'd1024 : alpha_init;
      alpha_delay = alpha_ecn;
      alpha_cur   = alpha_ecn;
   endfunction

   function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
         REG_GAIN_SHIFT: gain_shift = val[3:0];
         REG_ALPHA_INITIAL: begin
            alpha_init = val[10:0];
            load_alpha();
         end
         REG_QUEUE_THRESHOLD: queue_thr = val[15:0];
         REG_SEGMENT_BYTES: seg_bytes = val[13:0];
         default: ;
      endcase
   endfunction

   function logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function logic [10:0] smooth(logic [10:0] alpha, logic [31:0] count);
      longint unsigned frac, num;
      int unsigned sh;
      sh = (gain_shift > 4'd10) ? 10 : gain_shift;
      frac = 0;
      if (total_bytes != 0) begin
         frac = (64'(count) * 1024) / total_bytes;
         if (frac > 1024) frac = 1024;
      end
      num = 64'(alpha) * ((64'd1 << sh) - 1) + frac;
      return 11'(num >> sh);
   endfunction

   function logic [31:0] scale_half(logic [31:0] cwnd, logic [10:0] alpha);
      return 32'((64'(cwnd) * (64'd2048 - alpha)) >> 11);
   endfunction

   function void note_ack(ack_word_type a);
      logic [31:0] seg, bytes, base, val, diff;
      longint unsigned queued;
      window_word_type w;
      seg   = (seg_bytes == 0) ? 32'd1 : 32'(seg_bytes);
      bytes = 32'(a.segs) * seg;
      w.cwnd = a.cwnd; w.ssthresh = a.cwnd; w.cut = 0; w.closed = 0;
      acks_seen++;
      total_bytes = sat_add(total_bytes, bytes);
      if (a.rtt != 0) begin
         base = (a.min_rtt > a.rtt) ? 32'(a.rtt) : 32'(a.min_rtt);
         queued = (64'(a.cwnd / seg) * (64'(a.rtt) - base)) / a.rtt;
         if (queued >= queue_thr) begin
            delay_flag  = 1;
            delay_bytes = sat_add(delay_bytes, bytes);
         end
      end
      if (a.ece) ecn_bytes = sat_add(ecn_bytes, bytes);
      if (!round_armed) begin
         round_end   = a.next_tx;
         round_armed = 1;
      end
      diff = a.acked - round_end;
      if ((a.kind == KIND_ELEPHANT || a.kind == KIND_MOUSE) && !diff[31]) begin
         if (a.kind == KIND_ELEPHANT) begin
            alpha_delay = smooth(alpha_delay, delay_bytes);
            alpha_cur   = alpha_delay;
            if (delay_flag) begin
               val = scale_half(a.cwnd, alpha_delay);
               w.ssthresh = (val > 2 * seg) ? val : 2 * seg;
               w.cwnd = w.ssthresh;
               w.cut  = 1;
               cuts++;
            end
         end else begin
            alpha_ecn = smooth(alpha_ecn, ecn_bytes);
            alpha_cur = alpha_ecn;
         end
         w.closed = 1;
         rounds++;
         round_end = a.next_tx;
         ecn_bytes = 0; delay_bytes = 0; total_bytes = 0;
         delay_flag = 0;
      end
      w.alpha = alpha_cur;
      w.cwr   = scale_half(w.cwnd, alpha_cur);
      owed_windows.push_back(w);
   endfunction

   function void check_result(window_word_type got);
      window_word_type e;
      if (owed_windows.size() == 0) begin
         $error("unexpected result word, nothing owed");
         errors++;
         return;
      end
      e = owed_windows.pop_front();
      words_checked++;
      if (got.alpha !== e.alpha) begin
         $error("alpha_now: expected %0d, got %0d", e.alpha, got.alpha); errors++;
      end
      if (got.cwnd !== e.cwnd) begin
         $error("cwnd_new: expected %0d, got %0d", e.cwnd, got.cwnd); errors++;
      end
      if (got.ssthresh !== e.ssthresh) begin
         $error("ssthresh_new: expected %0d, got %0d", e.ssthresh, got.ssthresh);
         errors++;
      end
      if (got.cut !== e.cut) begin
         $error("window_cut: expected %0b, got %0b", e.cut, got.cut); errors++;
      end
      if (got.closed !== e.closed) begin
         $error("round_closed: expected %0b, got %0b", e.closed, got.closed); errors++;
      end
      if (got.cwr !== e.cwr) begin
         $error("cwr_threshold: expected %0d, got %0d", e.cwr, got.cwr); errors++;
      end
   endfunction
endclass

module tb_top;
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int DRAIN_CYCLES = 200;   // a bit above the worst-case ACK latency

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [15:0] req_segments_acked = 0;
   logic [23:0] req_rtt_sample_us = 0;
   logic [23:0] req_min_rtt_us = 0;
   logic [31:0] req_cwnd_bytes = 0;
   logic        req_ece_received = 0;
   logic [1:0]  req_flow_kind = KIND_OTHER;
   logic [31:0] req_last_acked_seq = 0;
   logic [31:0] req_next_tx_seq = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [10:0] rsp_alpha_now;
   logic [31:0] rsp_cwnd_new, rsp_ssthresh_new, rsp_cwr_threshold;
   logic        rsp_window_cut, rsp_round_closed;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [3:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   alpha_tracker tracker = new();
   bit           hold_off_req = 0;   // main thread asks the receiver for a long stall
   int           cycle_count = 0;
   int           burst_left = 0;
   logic [31:0]  flow_seq;          // running acked sequence for well-formed flows

   delay_ecn_congestion_estimator_top DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("simulation failed");
         $finish;
      end
   end

   // Note each accepted ACK word and check each accepted result word. Values
   // read here are the ones present at the edge; the drivers update with NBAs.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            tracker.note_ack('{req_segments_acked, req_rtt_sample_us, req_min_rtt_us,
                               req_cwnd_bytes, req_ece_received, req_flow_kind,
                               req_last_acked_seq, req_next_tx_seq});
         if (rsp_valid && rsp_ready)
            tracker.check_result('{rsp_alpha_now, rsp_cwnd_new, rsp_ssthresh_new,
                                   rsp_window_cut, rsp_round_closed,
                                   rsp_cwr_threshold});
      end
   end

   // Receiver: pick a new random stall pattern at the end of each phase; on request, hold off for
   // a long stretch so the block backs up into its input.
   initial begin
      int mode, phase_left;
      mode = 0;
      phase_left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (700) @(posedge clock);
            hold_off_req = 0;
         end else begin
            if (phase_left == 0) begin
               mode = $urandom_range(0, 3);
               phase_left = 64;
            end
            phase_left--;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= (cycle_count % 8 < 2);
            endcase
         end
      end
   end

   // APB write: setup phase, then access phase; pready is tied high so the access phase never waits.
   task automatic csr_write(logic [1:0] idx, logic [31:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      tracker.write_reg(idx, val);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Hold the sender until every owed word is back, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.owed_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Offer one word and hold it until accepted; keep valid high across bursts.
   task automatic send_ack(ack_word_type a, bit bursty);
      int gap;
      req_valid          <= 1'b1;
      req_segments_acked <= a.segs;
      req_rtt_sample_us  <= a.rtt;
      req_min_rtt_us     <= a.min_rtt;
      req_cwnd_bytes     <= a.cwnd;
      req_ece_received   <= a.ece;
      req_flow_kind      <= a.kind;
      req_last_acked_seq <= a.acked;
      req_next_tx_seq    <= a.next_tx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (bursty) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
      end
   endtask

   // Mostly a well-behaved flow: acked walks forward, next_tx leads it, rtt
   // near min. The rest is noise over the whole field range.
   function automatic ack_word_type random_ack();
      ack_word_type a;
      int unsigned seg;
      seg = (tracker.seg_bytes == 0) ? 1 : tracker.seg_bytes;
      if ($urandom_range(0, 9) < 8) begin
         a.segs    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
         a.rtt     = ($urandom_range(0, 15) == 0) ? 24'd0 : 24'($urandom_range(100, 300000));
         a.min_rtt = ($urandom_range(0, 7) == 0) ? 24'($urandom)
                                                  : 24'(a.rtt - $urandom_range(0, a.rtt / 2));
         a.cwnd    = ($urandom_range(0, 7) == 0) ? $urandom
                                                  : 32'($urandom_range(2, 600) * seg);
         a.ece     = $urandom_range(0, 1);
         a.kind    = ($urandom_range(0, 9) == 0) ? 2'($urandom) :
                     ($urandom_range(0, 1) ? KIND_ELEPHANT : KIND_MOUSE);
         flow_seq  = flow_seq + a.segs * seg;
         a.acked   = flow_seq;
         a.next_tx = flow_seq + $urandom_range(0, 40 * seg);
      end else begin
         a = '{16'($urandom), 24'($urandom), 24'($urandom), $urandom, 1'($urandom),
               2'($urandom), $urandom, $urandom};
      end
      return a;
   endfunction

   initial begin
      ack_word_type a;
      int phase;
      flow_seq = $urandom;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed, reset defaults: first ACK latches the round end and closes at once.
      send_ack('{16'd10, 24'd2000, 24'd1000, 32'd536000, 1'b1, KIND_ELEPHANT,
                 32'd5000, 32'd5000}, 0);
      // no rtt sample, then rtt below min (queue forced to zero)
      send_ack('{16'd3, 24'd0, 24'd900, 32'd50000, 1'b0, KIND_OTHER, 32'd5100, 32'd9000}, 0);
      send_ack('{16'd3, 24'd500, 24'd900, 32'd50000, 1'b1, KIND_MOUSE, 32'd5200, 32'd9000}, 0);
      // mouse round end with ECE bytes
      send_ack('{16'd4, 24'd800, 24'd800, 32'd80000, 1'b1, KIND_MOUSE, 32'd9000, 32'd12000}, 0);
      // spare kind: count only
      send_ack('{16'd7, 24'd3000, 24'd10, 32'd900000, 1'b0, KIND_SPARE, 32'd20000,
                 32'd30000}, 0);
      // near-all-ones fields with a huge window; acked lies behind the round end, so no round closes
      send_ack('{16'hFFFF, 24'hFFFFFF, 24'd1, 32'hFFFF_FFFF, 1'b1, KIND_ELEPHANT,
                 32'hFFFF_FFFF, 32'h0000_0010}, 0);
      // sequence wrap: acked at the top of the space, then just past zero; both stay behind the round end
      send_ack('{16'd0, 24'd0, 24'd0, 32'd0, 1'b0, KIND_ELEPHANT, 32'hFFFF_FFF0, 32'd4}, 0);
      send_ack('{16'd1, 24'd1, 24'd0, 32'd0, 1'b0, KIND_ELEPHANT, 32'd4, 32'h8000_0004}, 0);
      // small-window elephant cut; the cut value stays above the two-segment floor
      send_ack('{16'd2, 24'd10000, 24'd100, 32'd6000, 1'b0, KIND_OTHER, 32'd5, 32'd9}, 0);
      send_ack('{16'd2, 24'd10000, 24'd100, 32'd6000, 1'b0, KIND_ELEPHANT,
                 32'h8000_0004, 32'h8000_0100}, 0);
      drain();

      // Extremes: fastest and slowest gain, alpha clamp, threshold 0 / max, seg 0.
      csr_write(REG_GAIN_SHIFT, 32'd0);
      csr_write(REG_ALPHA_INITIAL, 32'd0);
      csr_write(REG_QUEUE_THRESHOLD, 32'd0);
      csr_write(REG_SEGMENT_BYTES, 32'd0);
      send_ack('{16'd100, 24'd50, 24'd50, 32'd1000, 1'b1, KIND_ELEPHANT, 32'd0, 32'd0}, 0);
      send_ack('{16'd100, 24'd0, 24'd50, 32'd1000, 1'b1, KIND_MOUSE, 32'd10, 32'd20}, 0);
      drain();
      csr_write(REG_GAIN_SHIFT, 32'd15);
      csr_write(REG_ALPHA_INITIAL, 32'd2047);
      csr_write(REG_QUEUE_THRESHOLD, 32'd65535);
      csr_write(REG_SEGMENT_BYTES, 32'd16383);
      // saturate the byte counters, then close rounds on both kinds
      repeat (5) send_ack('{16'hFFFF, 24'd9000, 24'd1, 32'hFFFF_FFFF, 1'b1, KIND_OTHER,
                             32'd0, 32'd100}, 0);
      send_ack('{16'hFFFF, 24'd9000, 24'd1, 32'hFFFF_FFFF, 1'b1, KIND_MOUSE,
                 32'd200, 32'd300}, 0);
      send_ack('{16'd1, 24'd9000, 24'd1, 32'd100, 1'b0, KIND_ELEPHANT, 32'd400, 32'd500}, 0);
      drain();
      csr_write(REG_GAIN_SHIFT, 32'd10);
      csr_write(REG_ALPHA_INITIAL, 32'd1024);

      // Random phases, each under its own register setting.
      for (phase = 0; phase < 6; phase++) begin
         csr_write(REG_GAIN_SHIFT, $urandom_range(0, 15));
         csr_write(REG_ALPHA_INITIAL, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                                  : $urandom_range(0, 1024));
         csr_write(REG_QUEUE_THRESHOLD, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                                    : $urandom_range(0, 40));
         csr_write(REG_SEGMENT_BYTES, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 16383)
                                                                  : $urandom_range(1, 9000));
         for (int n = 0; n < 155; n++) begin
            // midway through one phase, freeze the receiver and keep pushing
            if (phase == 2 && n == 40) hold_off_req = 1;
            send_ack(random_ack(), 1);
         end
         drain();
      end

      $display("checked %0d result words for %0d ACK words: %0d rounds closed, %0d cuts",
               tracker.words_checked, tracker.acks_seen, tracker.rounds, tracker.cuts);
      $display("covered register extremes, counter saturation and sequence wrap");
      if (tracker.errors == 0 && tracker.owed_windows.size() == 0) begin
         $display("simulation ok");
      end else begin
         if (tracker.owed_windows.size() != 0)
            $error("%0d result words never arrived", tracker.owed_windows.size());
         $display("simulation failed");
      end
      $finish;
   end
endmodule
